FILE: rtl/core/pci_pkg.sv
package pci_pkg;

   localparam int PosW      = 11;
   localparam int WW        = 16;
   localparam int AttrW     = 25;
   localparam int FacW      = 32;
   localparam int DivStages = FacW;
   localparam int Latency   = DivStages + 5;

   localparam logic [6:0] EdgeFlatMask = 7'h7E;
   localparam logic [6:0] SpanFlatMask = 7'h7F;

   // partial remainder and dividend/quotient shift word of one divider
   typedef struct packed {
      logic [FacW-1:0] r;
      logic [FacW-1:0] n;
   } quo_type;

   typedef struct packed {
      logic                    mode;
      logic                    lin;
      logic signed [AttrW-1:0] attr_a;
      logic signed [AttrW:0]   attr_diff;
      logic [FacW-1:0]         lin_d;
      quo_type                 lin_q;
      logic [FacW-1:0]         per_d;
      quo_type                 per_q;
   } div_type;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic quo_type div_step(input logic [FacW-1:0] d, input quo_type cur);
      logic [FacW:0]   rs;
      logic [FacW+1:0] diff;
      quo_type         nxt;
      rs   = {cur.r, cur.n[FacW-1]};
      diff = {1'b0, rs} - {2'b00, d};
      if (!diff[FacW+1]) begin
         nxt.r = diff[FacW-1:0];
         nxt.n = {cur.n[FacW-2:0], 1'b1};
      end else begin
         nxt.r = rs[FacW-1:0];
         nxt.n = {cur.n[FacW-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

FILE: rtl/core/perspective_correct_interpolator.sv
// Perspective-correct attribute interpolator. One item per clock cycle, no
// stall: busy is tied low and every accepted item comes back on the rsp_
// ports, marked by rsp_strobe for a single cycle, in the order taken.
// The receiver cannot hold results off, so capture each one on the strobe.
// The pipeline is made of the two 32-bit restoring dividers (linear and
// perspective factor), which resolve one quotient bit per pipeline stage,
// plus three front stages (differences, w products, denominator sum) and
// two blend stages (multiply, add/shift). A zero divisor yields a factor
// of zero. The blends are exact; the values delivered are the low 25 bits
// after a floor shift by the precision.
module perspective_correct_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [pci_pkg::WW-1:0]           req_w_start,
   input  logic [pci_pkg::WW-1:0]           req_w_end,
   input  logic signed [pci_pkg::PosW-1:0]  req_pos,
   input  logic signed [pci_pkg::PosW-1:0]  req_pos_min,
   input  logic signed [pci_pkg::PosW-1:0]  req_pos_max,
   input  logic signed [pci_pkg::AttrW-1:0] req_attr_a,
   input  logic signed [pci_pkg::AttrW-1:0] req_attr_b,
   output logic                             rsp_strobe,
   output logic [pci_pkg::FacW-1:0]         rsp_factor_linear,
   output logic [pci_pkg::FacW-1:0]         rsp_factor_perspective,
   output logic                             rsp_use_linear,
   output logic signed [pci_pkg::AttrW-1:0] rsp_value_perspective,
   output logic signed [pci_pkg::AttrW-1:0] rsp_value_linear
);

   localparam int FW = pci_pkg::FacW;
   localparam int AW = pci_pkg::AttrW;
   localparam int DS = pci_pkg::DivStages;

   assign busy = 1'b0;

   // ---------------- stage 1: differences and w weights ----------------
   logic                 take;
   logic signed [pci_pkg::PosW:0] d0, d1, dl;
   logic [FW-1:0]        t0_in, t1_in, len_in, t0s_in;
   logic [pci_pkg::WW-1:0] wn_in, wa_in, wb_in;
   logic [6:0]           mask;
   logic                 lin_in;

   logic                 v1_ff, mode1_ff, lin1_ff;
   logic [FW-1:0]        t0_1_ff, t1_1_ff, len1_ff, t0s1_ff;
   logic [pci_pkg::WW-1:0] wn1_ff, wa1_ff, wb1_ff;
   logic signed [AW-1:0] a1_ff;
   logic signed [AW:0]   diff1_ff;

   always_comb begin
      take   = start & ~busy;
      d0     = {req_pos[pci_pkg::PosW-1], req_pos} - {req_pos_min[pci_pkg::PosW-1], req_pos_min};
      d1     = {req_pos_max[pci_pkg::PosW-1], req_pos_max} - {req_pos[pci_pkg::PosW-1], req_pos};
      dl     = {req_pos_max[pci_pkg::PosW-1], req_pos_max}
             - {req_pos_min[pci_pkg::PosW-1], req_pos_min};
      t0_in  = {{(FW-pci_pkg::PosW-1){d0[pci_pkg::PosW]}}, d0};
      t1_in  = {{(FW-pci_pkg::PosW-1){d1[pci_pkg::PosW]}}, d1};
      len_in = {{(FW-pci_pkg::PosW-1){dl[pci_pkg::PosW]}}, dl};
      t0s_in = req_mode ? {t0_in[FW-9:0], 8'd0} : {t0_in[FW-10:0], 9'd0};
      if (req_mode) begin
         wn_in = req_w_start;
         wa_in = req_w_start;
         wb_in = req_w_end;
      end else begin
         // edge mode: halve w, round the start weight up on odd/even pairs
         wn_in = {1'b0, req_w_start[pci_pkg::WW-1:1]};
         wb_in = {1'b0, req_w_end[pci_pkg::WW-1:1]};
         wa_in = wn_in + {{(pci_pkg::WW-1){1'b0}}, req_w_start[0] & ~req_w_end[0]};
      end
      mask   = req_mode ? pci_pkg::SpanFlatMask : pci_pkg::EdgeFlatMask;
      lin_in = (req_w_start == req_w_end) && ((req_w_start[6:0] & mask) == 7'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      mode1_ff <= req_mode;
      lin1_ff  <= lin_in;
      t0_1_ff  <= t0_in;
      t1_1_ff  <= t1_in;
      len1_ff  <= len_in;
      t0s1_ff  <= t0s_in;
      wn1_ff   <= wn_in;
      wa1_ff   <= wa_in;
      wb1_ff   <= wb_in;
      a1_ff    <= req_attr_a;
      diff1_ff <= {req_attr_b[AW-1], req_attr_b} - {req_attr_a[AW-1], req_attr_a};
   end

   // ---------------- stage 2: w products, wrapped to 32 bits ----------------
   logic [FW+pci_pkg::WW-1:0] p_t1, p_t0, p_num;
   logic                 v2_ff, mode2_ff, lin2_ff;
   logic [FW-1:0]        m1_2_ff, m2_2_ff, num2_ff, len2_ff, t0s2_ff;
   logic signed [AW-1:0] a2_ff;
   logic signed [AW:0]   diff2_ff;

   always_comb begin
      p_t1  = t1_1_ff * wb1_ff;
      p_t0  = t0_1_ff * wa1_ff;
      p_num = t0s1_ff * wn1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mode2_ff <= mode1_ff;
      lin2_ff  <= lin1_ff;
      m1_2_ff  <= p_t1[FW-1:0];
      m2_2_ff  <= p_t0[FW-1:0];
      num2_ff  <= p_num[FW-1:0];
      len2_ff  <= len1_ff;
      t0s2_ff  <= t0s1_ff;
      a2_ff    <= a1_ff;
      diff2_ff <= diff1_ff;
   end

   // ---------------- stage 3 and divider stages ----------------
   pci_pkg::div_type dv_ff [0:DS];
   logic             dvv_ff [0:DS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DS; k++) dvv_ff[k] <= 1'b0;
      end else begin
         dvv_ff[0] <= v2_ff;
         for (int k = 0; k < DS; k++) dvv_ff[k+1] <= dvv_ff[k];
      end
      dv_ff[0].mode      <= mode2_ff;
      dv_ff[0].lin       <= lin2_ff;
      dv_ff[0].attr_a    <= a2_ff;
      dv_ff[0].attr_diff <= diff2_ff;
      dv_ff[0].lin_d     <= len2_ff;
      dv_ff[0].lin_q     <= '{r: '0, n: t0s2_ff};
      dv_ff[0].per_d     <= m1_2_ff + m2_2_ff;
      dv_ff[0].per_q     <= '{r: '0, n: num2_ff};
      // advance one quotient bit per stage in both dividers
      for (int k = 0; k < DS; k++) begin
         dv_ff[k+1].mode      <= dv_ff[k].mode;
         dv_ff[k+1].lin       <= dv_ff[k].lin;
         dv_ff[k+1].attr_a    <= dv_ff[k].attr_a;
         dv_ff[k+1].attr_diff <= dv_ff[k].attr_diff;
         dv_ff[k+1].lin_d     <= dv_ff[k].lin_d;
         dv_ff[k+1].per_d     <= dv_ff[k].per_d;
         dv_ff[k+1].lin_q     <= pci_pkg::div_step(dv_ff[k].lin_d, dv_ff[k].lin_q);
         dv_ff[k+1].per_q     <= pci_pkg::div_step(dv_ff[k].per_d, dv_ff[k].per_q);
      end
   end

   // ---------------- blend stage 1: factor products ----------------
   pci_pkg::div_type     dq;
   logic [FW-1:0]        f_lin_in, f_per_in, f_sel;
   logic                 vb1_ff, modeb1_ff, linb1_ff;
   logic [FW-1:0]        flin_b1_ff, fper_b1_ff;
   logic signed [AW-1:0] ab1_ff;
   logic signed [AW+FW+1:0] prod_sel_ff, prod_lin_ff;

   always_comb begin
      dq       = dv_ff[DS];
      f_lin_in = (dq.lin_d == '0) ? '0 : dq.lin_q.n;
      f_per_in = (dq.per_d == '0) ? '0 : dq.per_q.n;
      f_sel    = dq.lin ? f_lin_in : f_per_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb1_ff <= 1'b0;
      end else begin
         vb1_ff <= dvv_ff[DS];
      end
      modeb1_ff   <= dq.mode;
      linb1_ff    <= dq.lin;
      flin_b1_ff  <= f_lin_in;
      fper_b1_ff  <= f_per_in;
      ab1_ff      <= dq.attr_a;
      prod_sel_ff <= dq.attr_diff * $signed({1'b0, f_sel});
      prod_lin_ff <= dq.attr_diff * $signed({1'b0, f_lin_in});
   end

   // ---------------- blend stage 2: a*2^P + (b-a)*f, floor shift ----------------
   logic signed [AW+FW+2:0] a_sh, v_sel, v_lin, s_sel, s_lin;

   always_comb begin
      a_sh  = {{(FW+3){ab1_ff[AW-1]}}, ab1_ff};
      a_sh  = modeb1_ff ? (a_sh <<< 8) : (a_sh <<< 9);
      v_sel = a_sh + {prod_sel_ff[AW+FW+1], prod_sel_ff};
      v_lin = a_sh + {prod_lin_ff[AW+FW+1], prod_lin_ff};
      s_sel = modeb1_ff ? (v_sel >>> 8) : (v_sel >>> 9);
      s_lin = modeb1_ff ? (v_lin >>> 8) : (v_lin >>> 9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= vb1_ff;
      end
      rsp_factor_linear      <= flin_b1_ff;
      rsp_factor_perspective <= fper_b1_ff;
      rsp_use_linear         <= linb1_ff;
      rsp_value_perspective  <= s_sel[AW-1:0];
      rsp_value_linear       <= s_lin[AW-1:0];
   end

   // ---------------- assertions ----------------
   a_no_stall: assert property (@(posedge clock) !busy)
      else $error("busy raised on a non-stalling pipeline");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(pci_pkg::Latency) rsp_strobe)
      else $error("accepted item produced no result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, pci_pkg::Latency))
      else $error("result strobe out of step with accepted items");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   a_lin_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_use_linear) |-> (rsp_value_perspective == rsp_value_linear))
      else $error("linear override gave differing blends");

endmodule
